>>> rtl/stt_pkg.sv
// shared widths, types and codes of the sphere-triangle overlap test
`timescale 1ns / 1ps
package stt_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int RAD_W = 31;
  localparam int TOL_W = 16;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 1;

  // internal widths, all exact
  localparam int DIFF_W = COORD_W + 1;
  localparam int DOT_W = 2 * DIFF_W + 2;
  localparam int PROD_W = 2 * DOT_W;
  localparam int NUM_W = PROD_W + 2;
  localparam int SUM_W = NUM_W + 1;
  localparam int ERR_W = NUM_W + 2;
  localparam int RSQ_W = 2 * RAD_W;
  localparam int RNN_W = RSQ_W + 1 + DOT_W;
  localparam int ELHS_W = PROD_W + 1;
  localparam int TOLD_W = TOL_W + 1 + NUM_W;
  localparam int BARY_FRAC_BITS = 30;
  localparam int CMP_W = ERR_W + BARY_FRAC_BITS + 1;

  // register reset values
  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(65536);
  localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL = 1'b1;

  // result codes
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_CENTER = 2'd2,
    KIND_EDGE = 2'd3
  } kind_t;

  // point and difference vector
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pt_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } vec_t;

  // per-item flags carried down the pipe
  typedef struct packed {
    logic [2:0] vin;
    logic [2:0] nnz;
    logic [2:0] aneg;
    logic [2:0] span;
  } flag_t;

endpackage

>>> rtl/stt_in_if.sv
// input channel: triangle vertices and projected centre
`timescale 1ns / 1ps
interface stt_in_if;
  import stt_pkg::*;

  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] v0_x;
  logic signed [COORD_W-1:0] v0_y;
  logic signed [COORD_W-1:0] v0_z;
  logic signed [COORD_W-1:0] v1_x;
  logic signed [COORD_W-1:0] v1_y;
  logic signed [COORD_W-1:0] v1_z;
  logic signed [COORD_W-1:0] v2_x;
  logic signed [COORD_W-1:0] v2_y;
  logic signed [COORD_W-1:0] v2_z;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
           center_x, center_y, center_z,
    input ready
  );
  modport sink (
    input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
          center_x, center_y, center_z,
    output ready
  );
endinterface

>>> rtl/stt_out_if.sv
// output channel: overlap result
`timescale 1ns / 1ps
interface stt_out_if;
  logic valid;
  logic ready;
  logic touches;
  logic [1:0] hit_kind;

  modport source (output valid, touches, hit_kind, input ready);
  modport sink (input valid, touches, hit_kind, output ready);
endinterface

>>> rtl/stt_mul.sv
// two-stage signed multiplier built from 33x33 partial products
`timescale 1ns / 1ps
module stt_mul #(
  parameter int WA = 68,
  parameter int WB = 68
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [WA-1:0]      a,
  input  logic signed [WB-1:0]      b,
  output logic signed [WA+WB-1:0]   p
);
  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int WP = WA + WB;

  logic signed [NA*32-1:0] ax;
  logic signed [NB*32-1:0] bx;
  logic signed [32:0] ac [NA];
  logic signed [32:0] bc [NB];
  logic signed [65:0] pp [NA][NB];
  logic signed [WP-1:0] acc;

  // split into chunks, only the top chunk carries the sign
  assign ax = (NA*32)'(a);
  assign bx = (NB*32)'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) ac[i] = $signed({ax[i*32+31], ax[i*32 +: 32]});
      else ac[i] = $signed({1'b0, ax[i*32 +: 32]});
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) bc[j] = $signed({bx[j*32+31], bx[j*32 +: 32]});
      else bc[j] = $signed({1'b0, bx[j*32 +: 32]});
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ac[i] * bc[j];
        end
      end
    end
  end

  // weighted sum of partials
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (WP'(pp[i][j]) <<< (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc;
    end
  end
endmodule

>>> rtl/stt_dot.sv
// two-stage 3-d dot product of difference vectors
`timescale 1ns / 1ps
module stt_dot (
  input  logic                           clk,
  input  logic                           en,
  input  stt_pkg::vec_t                  a,
  input  stt_pkg::vec_t                  b,
  output logic signed [stt_pkg::DOT_W-1:0] dot
);
  import stt_pkg::*;

  logic signed [2*DIFF_W-1:0] px;
  logic signed [2*DIFF_W-1:0] py;
  logic signed [2*DIFF_W-1:0] pz;

  // component products
  always_ff @(posedge clk) begin
    if (en) begin
      px <= a.x * b.x;
      py <= a.y * b.y;
      pz <= a.z * b.z;
    end
  end

  // sum of components
  always_ff @(posedge clk) begin
    if (en) begin
      dot <= DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
    end
  end
endmodule

>>> rtl/sphere_triangle_overlap_test.sv
// Throughput: one item per cycle; the whole pipe advances together and holds
//   when the output register is full and not taken.
// Critical units: 33x33 partial products of the 68x68 and 17x138 multipliers.
// Reset clears all stage valid bits and loads radius 1.0 and tolerance 1.
// top level of the sphere-triangle overlap test
`timescale 1ns / 1ps
module sphere_triangle_overlap_test (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [stt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stt_pkg::CFG_W-1:0]          cfg_wdata,
  stt_in_if.sink                             in_ch,
  stt_out_if.source                          out_ch
);
  import stt_pkg::*;

  localparam int NSTG = 12;

  function automatic vec_t vsub(pt_t a, pt_t b);
    vec_t r;
    r.x = DIFF_W'(a.x) - DIFF_W'(b.x);
    r.y = DIFF_W'(a.y) - DIFF_W'(b.y);
    r.z = DIFF_W'(a.z) - DIFF_W'(b.z);
    return r;
  endfunction

  logic en;
  logic [NSTG-1:0] vld;

  logic [RAD_W-1:0] sphere_radius;
  logic [TOL_W-1:0] bary_tolerance;
  logic [RSQ_W-1:0] rad_sq;

  // pipe advances unless the output holds an untaken item
  assign en = !vld[NSTG-1] || out_ch.ready;
  assign in_ch.ready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= RADIUS_RST;
      bary_tolerance <= TOL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RADIUS: sphere_radius <= cfg_wdata[RAD_W-1:0];
        CFG_TOL: bary_tolerance <= cfg_wdata[TOL_W-1:0];
      endcase
    end
  end

  // squared radius
  always_ff @(posedge clk) begin
    rad_sq <= RSQ_W'(sphere_radius) * RSQ_W'(sphere_radius);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_ch.valid};
    end
  end

  // stage 0: capture the item
  pt_t p0, p1, p2, pc;
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= '{x: in_ch.v0_x, y: in_ch.v0_y, z: in_ch.v0_z};
      p1 <= '{x: in_ch.v1_x, y: in_ch.v1_y, z: in_ch.v1_z};
      p2 <= '{x: in_ch.v2_x, y: in_ch.v2_y, z: in_ch.v2_z};
      pc <= '{x: in_ch.center_x, y: in_ch.center_y, z: in_ch.center_z};
    end
  end

  // stage 1: difference vectors
  vec_t d0, d1, d2, u, v, w, w1, n12;
  always_ff @(posedge clk) begin
    if (en) begin
      d0 <= vsub(p0, pc);
      d1 <= vsub(p1, pc);
      d2 <= vsub(p2, pc);
      u <= vsub(p1, p0);
      v <= vsub(p2, p0);
      w <= vsub(pc, p0);
      w1 <= vsub(pc, p1);
      n12 <= vsub(p2, p1);
    end
  end

  // stages 2-3: dot products
  logic signed [DOT_W-1:0] dd0, dd1, dd2, uu, vv, uv, wu, wv, nn12, an12;
  stt_dot u_dd0 (.clk, .en, .a(d0), .b(d0), .dot(dd0));
  stt_dot u_dd1 (.clk, .en, .a(d1), .b(d1), .dot(dd1));
  stt_dot u_dd2 (.clk, .en, .a(d2), .b(d2), .dot(dd2));
  stt_dot u_uu (.clk, .en, .a(u), .b(u), .dot(uu));
  stt_dot u_vv (.clk, .en, .a(v), .b(v), .dot(vv));
  stt_dot u_uv (.clk, .en, .a(u), .b(v), .dot(uv));
  stt_dot u_wu (.clk, .en, .a(w), .b(u), .dot(wu));
  stt_dot u_wv (.clk, .en, .a(w), .b(v), .dot(wv));
  stt_dot u_nn12 (.clk, .en, .a(n12), .b(n12), .dot(nn12));
  stt_dot u_an12 (.clk, .en, .a(n12), .b(w1), .dot(an12));

  // edge operands: v0-v1, v0-v2, v1-v2
  logic signed [DOT_W-1:0] e_nn [3];
  logic signed [DOT_W-1:0] e_an [3];
  logic signed [DOT_W-1:0] e_ww [3];
  always_comb begin
    e_nn[0] = uu;   e_an[0] = wu;   e_ww[0] = dd0;
    e_nn[1] = vv;   e_an[1] = wv;   e_ww[1] = dd0;
    e_nn[2] = nn12; e_an[2] = an12; e_ww[2] = dd1;
  end

  // stages 4-5: products of dot products
  logic signed [PROD_W-1:0] uvuv, uuvv, uvwv, vvwu, uvwu, uuwv;
  logic signed [PROD_W-1:0] wwnn [3];
  logic signed [PROD_W-1:0] anan [3];
  logic signed [RNN_W-1:0] rnn [3];
  logic signed [RSQ_W:0] rsq_s;
  assign rsq_s = $signed({1'b0, rad_sq});

  stt_mul #(.WA(DOT_W), .WB(DOT_W)) u_uvuv (.clk, .en, .a(uv), .b(uv), .p(uvuv));
  stt_mul #(.WA(DOT_W), .WB(DOT_W)) u_uuvv (.clk, .en, .a(uu), .b(vv), .p(uuvv));
  stt_mul #(.WA(DOT_W), .WB(DOT_W)) u_uvwv (.clk, .en, .a(uv), .b(wv), .p(uvwv));
  stt_mul #(.WA(DOT_W), .WB(DOT_W)) u_vvwu (.clk, .en, .a(vv), .b(wu), .p(vvwu));
  stt_mul #(.WA(DOT_W), .WB(DOT_W)) u_uvwu (.clk, .en, .a(uv), .b(wu), .p(uvwu));
  stt_mul #(.WA(DOT_W), .WB(DOT_W)) u_uuwv (.clk, .en, .a(uu), .b(wv), .p(uuwv));

  for (genvar e = 0; e < 3; e++) begin : g_edge
    stt_mul #(.WA(DOT_W), .WB(DOT_W)) u_wwnn (
      .clk, .en, .a(e_ww[e]), .b(e_nn[e]), .p(wwnn[e]));
    stt_mul #(.WA(DOT_W), .WB(DOT_W)) u_anan (
      .clk, .en, .a(e_an[e]), .b(e_an[e]), .p(anan[e]));
    stt_mul #(.WA(RSQ_W + 1), .WB(DOT_W)) u_rnn (
      .clk, .en, .a(rsq_s), .b(e_nn[e]), .p(rnn[e]));
  end

  // stage 4: vertex and edge span flags
  flag_t f4, f5, f6;
  always_ff @(posedge clk) begin
    if (en) begin
      f4.vin[0] <= $unsigned(dd0) < DOT_W'(rad_sq);
      f4.vin[1] <= $unsigned(dd1) < DOT_W'(rad_sq);
      f4.vin[2] <= $unsigned(dd2) < DOT_W'(rad_sq);
      for (int e = 0; e < 3; e++) begin
        f4.nnz[e] <= e_nn[e] == '0;
        f4.aneg[e] <= e_an[e][DOT_W-1];
        f4.span[e] <= !e_an[e][DOT_W-1] && (e_an[e] <= e_nn[e]);
      end
      f5 <= f4;
      f6 <= f5;
    end
  end

  // stage 6: determinant, numerators, edge distance terms
  logic signed [NUM_W-1:0] d6, ns6, nt6;
  logic signed [ELHS_W-1:0] elhs6 [3];
  logic signed [RNN_W-1:0] erhs6 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      d6 <= NUM_W'(uvuv) - NUM_W'(uuvv);
      ns6 <= NUM_W'(uvwv) - NUM_W'(vvwu);
      nt6 <= NUM_W'(uvwu) - NUM_W'(uuwv);
      for (int e = 0; e < 3; e++) begin
        elhs6[e] <= ELHS_W'(wwnn[e]) - ELHS_W'(anan[e]);
        erhs6[e] <= rnn[e];
      end
    end
  end

  // stage 7: sign normalization and edge decisions
  logic signed [NUM_W-1:0] dn7, ns7, nt7;
  logic dz7, vany7, seg7;
  logic [2:0] ehit;
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      ehit[e] = !f6.nnz[e] && (NUM_W'(elhs6[e]) < NUM_W'(erhs6[e]));
    end
    // fallback vertex: a when before the span, b when beyond
    ehit[0] = ehit[0] && (f6.span[0] || (f6.aneg[0] ? f6.vin[0] : f6.vin[1]));
    ehit[1] = ehit[1] && (f6.span[1] || (f6.aneg[1] ? f6.vin[0] : f6.vin[2]));
    ehit[2] = ehit[2] && (f6.span[2] || (f6.aneg[2] ? f6.vin[1] : f6.vin[2]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn7 <= d6[NUM_W-1] ? -d6 : d6;
      ns7 <= d6[NUM_W-1] ? -ns6 : ns6;
      nt7 <= d6[NUM_W-1] ? -nt6 : nt6;
      dz7 <= d6 == '0;
      vany7 <= |f6.vin;
      seg7 <= |ehit;
    end
  end

  // stages 8-9: tolerance times determinant
  logic signed [TOL_W:0] tol_s;
  logic signed [TOLD_W-1:0] told9;
  assign tol_s = $signed({1'b0, bary_tolerance});
  stt_mul #(.WA(TOL_W + 1), .WB(NUM_W)) u_told (
    .clk, .en, .a(tol_s), .b(dn7), .p(told9));

  // stage 8: s + t
  logic signed [SUM_W-1:0] s8;
  logic signed [NUM_W-1:0] dn8, ns8, nt8;
  logic dz8, vany8, seg8;
  always_ff @(posedge clk) begin
    if (en) begin
      s8 <= SUM_W'(ns7) + SUM_W'(nt7);
      dn8 <= dn7;
      ns8 <= ns7;
      nt8 <= nt7;
      dz8 <= dz7;
      vany8 <= vany7;
      seg8 <= seg7;
    end
  end

  // stage 9: s + t - 1, magnitudes, interior test
  logic signed [ERR_W-1:0] e9;
  logic [NUM_W-1:0] absns9, absnt9;
  logic inter9, dz9, vany9, seg9;
  always_ff @(posedge clk) begin
    if (en) begin
      e9 <= ERR_W'(s8) - ERR_W'(dn8);
      absns9 <= ns8[NUM_W-1] ? $unsigned(-ns8) : $unsigned(ns8);
      absnt9 <= nt8[NUM_W-1] ? $unsigned(-nt8) : $unsigned(nt8);
      inter9 <= (ns8 > 0) && (nt8 > 0) && (s8 < SUM_W'(dn8));
      dz9 <= dz8;
      vany9 <= vany8;
      seg9 <= seg8;
    end
  end

  // stage 10: tolerance compares on s and t
  logic [ERR_W-1:0] abse10;
  logic [CMP_W-1:0] told10;
  logic tns10, tnt10, inter10, dz10, vany10, seg10;
  logic [CMP_W-1:0] told9_u;
  assign told9_u = CMP_W'($unsigned(told9));
  always_ff @(posedge clk) begin
    if (en) begin
      abse10 <= e9[ERR_W-1] ? $unsigned(-e9) : $unsigned(e9);
      tns10 <= (CMP_W'(absns9) << BARY_FRAC_BITS) < told9_u;
      tnt10 <= (CMP_W'(absnt9) << BARY_FRAC_BITS) < told9_u;
      told10 <= told9_u;
      inter10 <= inter9;
      dz10 <= dz9;
      vany10 <= vany9;
      seg10 <= seg9;
    end
  end

  // stage 11: final decision into the output register
  logic tne10;
  logic center10;
  kind_t kind_next;
  kind_t kind;
  assign tne10 = (CMP_W'(abse10) << BARY_FRAC_BITS) < told10;
  assign center10 = !dz10 && (tns10 || tnt10 || tne10 || inter10);

  always_comb begin
    priority if (vany10) kind_next = KIND_VERTEX;
    else if (center10) kind_next = KIND_CENTER;
    else if (seg10) kind_next = KIND_EDGE;
    else kind_next = KIND_NONE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind <= kind_next;
    end
  end

  assign out_ch.valid = vld[NSTG-1];
  assign out_ch.hit_kind = kind;
  assign out_ch.touches = kind != KIND_NONE;

  // checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");

  a_valid_shift: assert property (@(posedge clk) disable iff (rst)
    (in_ch.ready && vld[0]) |=> vld[1])
    else $error("item lost between first stages");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTG-2] && !en) |=> vld[NSTG-2])
    else $error("item dropped during stall");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("valid bits not cleared by reset");
endmodule
